/* rtl/tes_pkg.sv */
// ----------------------------------------------------------------------------
// tes_pkg
// Shared types and constants of the timed event sequencer.
// ----------------------------------------------------------------------------
package tes_pkg;

  localparam int MAX_EVENTS_DEF = 64;
  localparam int PUMPS_DEF      = 16;
  localparam int SETS_PER_TICK  = 16;

  localparam int TIME_W   = 24;
  localparam int PUMP_W   = 5;
  localparam int LEVEL_W  = 8;
  localparam int TAG_W    = 8;
  localparam int PCT_W    = 7;
  localparam int IVAL_W   = 16;
  localparam int ENTRY_W  = TIME_W + PUMP_W + LEVEL_W;
  localparam int NUM_W    = TIME_W + PCT_W;
  localparam int FIRE_W   = 5;
  localparam int DSTEP_W  = 3;

  localparam logic [TIME_W-1:0] TIME_MAX    = '1;
  localparam logic [PCT_W-1:0]  PCT_FULL    = 7'd100;
  localparam logic [PUMP_W-1:0] PUMP_CNT_RST = 5'd16;
  localparam logic [IVAL_W-1:0] IVAL_RST    = 16'd1000;
  localparam logic [DSTEP_W-1:0] DIV_LAST   = 3'd6;

  // request codes
  localparam logic [2:0] FN_LOAD  = 3'd0;
  localparam logic [2:0] FN_START = 3'd1;
  localparam logic [2:0] FN_ESTOP = 3'd2;
  localparam logic [2:0] FN_SHUT  = 3'd3;
  localparam logic [2:0] FN_TICK  = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_PUMP     = 2'd0;
  localparam logic [1:0] KIND_STATE    = 2'd1;
  localparam logic [1:0] KIND_PROGRESS = 2'd2;
  localparam logic [1:0] KIND_ENDED    = 2'd3;

  // configuration register indexes
  localparam logic CFG_PUMP_COUNT = 1'b0;
  localparam logic CFG_INTERVAL   = 1'b1;

  typedef enum logic [1:0] {
    MODE_IDLE     = 2'd0,
    MODE_ACTIVE   = 2'd1,
    MODE_STOPPING = 2'd2
  } mode_t;

  typedef enum logic [3:0] {
    S_WAIT,
    S_TRD,
    S_PCT,
    S_DIV,
    S_PEMIT,
    S_FA,
    S_FB,
    S_P100,
    S_END,
    S_END2,
    S_SHUT
  } seq_state_t;

endpackage

/* rtl/timed_event_sequencer.sv */
// ----------------------------------------------------------------------------
// timed_event_sequencer
// Runs a loaded time program of pump events, one request at a time.
// ----------------------------------------------------------------------------
// Results: a load takes effect at accept, no result; start and the shutdown
//   state update appear in the cycle after accept, then one result per cycle.
// Tick: table read, product, 7 divider steps (skipped when full), progress
//   report, then a read-ahead and a result per pump set, end reports last.
// Throughput: one request at a time, busy falls with the last result.
// Reset: synchronous, active low; the table is not cleared. No output stall.
// ----------------------------------------------------------------------------
module timed_event_sequencer
  import tes_pkg::*;
#(
  parameter int MAX_EVENTS = MAX_EVENTS_DEF,
  parameter int PUMPS      = PUMPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  // request channel
  input  logic                start,
  output logic                busy,
  input  logic [2:0]          in_func,
  input  logic [TIME_W-1:0]   in_event_time_ms,
  input  logic [PUMP_W-1:0]   in_pump_index,
  input  logic [LEVEL_W-1:0]  in_pump_level,
  input  logic [TAG_W-1:0]    in_program_tag,
  // result channel
  output logic                out_strobe,
  output logic [1:0]          out_kind,
  output logic [PUMP_W-1:0]   out_pump,
  output logic [LEVEL_W-1:0]  out_level,
  output logic [PCT_W-1:0]    out_percent,
  output logic [1:0]          out_runner_mode,
  output logic [TAG_W-1:0]    out_tag,
  output logic                out_last,
  // configuration
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic                cfg_index,
  input  logic [IVAL_W-1:0]   cfg_data
);

  localparam int TOT_W    = $clog2(MAX_EVENTS + 1);
  localparam int ADDR_W   = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int SHUT_MAX = (PUMPS < SETS_PER_TICK) ? PUMPS : SETS_PER_TICK;

  seq_state_t            state_r, state_nxt;
  mode_t                 mode_r, mode_nxt;
  logic [TOT_W-1:0]      total_r, total_nxt;
  logic [TOT_W-1:0]      next_r, next_nxt;
  logic [TIME_W-1:0]     elapsed_r, elapsed_nxt;
  logic [IVAL_W-1:0]     since_r, since_nxt;
  logic [TAG_W-1:0]      tag_r, tag_nxt;
  logic [TIME_W-1:0]     last_time_r, last_time_nxt;
  logic [PUMP_W-1:0]     pump_count_r;
  logic [IVAL_W-1:0]     interval_r;

  logic [TIME_W-1:0]     gt_r, gt_nxt;
  logic [PUMP_W-1:0]     cur_pump_r, cur_pump_nxt;
  logic [LEVEL_W-1:0]    cur_level_r, cur_level_nxt;
  logic                  due_r, due_nxt;
  logic [FIRE_W-1:0]     fired_r, fired_nxt;
  logic [NUM_W-1:0]      rem_r, rem_nxt;
  logic [NUM_W-1:0]      dsh_r, dsh_nxt;
  logic [PCT_W-1:0]      q_r, q_nxt;
  logic [DSTEP_W-1:0]    step_r, step_nxt;
  logic [PUMP_W-1:0]     sh_i_r, sh_i_nxt;
  logic [PUMP_W-1:0]     sh_cnt_r, sh_cnt_nxt;

  logic                  out_strobe_r, out_strobe_nxt;
  logic [1:0]            out_kind_r, out_kind_nxt;
  logic [PUMP_W-1:0]     out_pump_r, out_pump_nxt;
  logic [LEVEL_W-1:0]    out_level_r, out_level_nxt;
  logic [PCT_W-1:0]      out_pct_r, out_pct_nxt;
  logic [1:0]            out_mode_r, out_mode_nxt;
  logic [TAG_W-1:0]      out_tag_r, out_tag_nxt;
  logic                  out_last_r, out_last_nxt;

  logic                  ram_we, ram_re;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;
  logic [TIME_W-1:0]     rd_time;
  logic [PUMP_W-1:0]     rd_pump;
  logic [LEVEL_W-1:0]    rd_level;

  logic                  accept;
  logic [PUMP_W-1:0]     shut_cnt;
  logic [IVAL_W:0]       since_inc;
  logic [TOT_W-1:0]      next_inc;
  logic                  due_now, table_end, more;

  tes_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_EVENTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign {rd_time, rd_pump, rd_level} = ram_rdata;

  assign busy      = (state_r != S_WAIT);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  assign shut_cnt  = (pump_count_r > PUMP_W'(SHUT_MAX)) ? PUMP_W'(SHUT_MAX) : pump_count_r;
  assign since_inc = {1'b0, since_r} + 1'b1;
  assign next_inc  = next_r + 1'b1;
  assign due_now   = (elapsed_r >= rd_time);
  assign table_end = (next_inc >= total_r);
  assign more      = !table_end && (fired_r < FIRE_W'(SETS_PER_TICK - 1)) && (rd_time == gt_r);

  assign ram_waddr = total_r[ADDR_W-1:0];
  assign ram_wdata = {in_event_time_ms, in_pump_index, in_pump_level};

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    total_nxt     = total_r;
    next_nxt      = next_r;
    elapsed_nxt   = elapsed_r;
    since_nxt     = since_r;
    tag_nxt       = tag_r;
    last_time_nxt = last_time_r;
    gt_nxt        = gt_r;
    cur_pump_nxt  = cur_pump_r;
    cur_level_nxt = cur_level_r;
    due_nxt       = due_r;
    fired_nxt     = fired_r;
    rem_nxt       = rem_r;
    dsh_nxt       = dsh_r;
    q_nxt         = q_r;
    step_nxt      = step_r;
    sh_i_nxt      = sh_i_r;
    sh_cnt_nxt    = sh_cnt_r;

    out_strobe_nxt = 1'b0;
    out_kind_nxt   = KIND_PUMP;
    out_pump_nxt   = '0;
    out_level_nxt  = '0;
    out_pct_nxt    = '0;
    out_mode_nxt   = MODE_IDLE;
    out_tag_nxt    = tag_r;
    out_last_nxt   = 1'b0;

    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_raddr = next_r[ADDR_W-1:0];

    case (state_r)
      S_WAIT: begin
        if (accept) begin
          case (in_func)
            FN_LOAD: begin
              if (mode_r == MODE_IDLE && total_r < TOT_W'(MAX_EVENTS) &&
                  in_pump_index != '0 && 7'(in_pump_index) <= 7'(PUMPS) &&
                  (total_r == '0 || in_event_time_ms >= last_time_r)) begin
                ram_we        = 1'b1;
                last_time_nxt = in_event_time_ms;
                total_nxt     = total_r + 1'b1;
              end
            end
            FN_START: begin
              if (mode_r == MODE_IDLE && total_r != '0) begin
                mode_nxt       = MODE_ACTIVE;
                tag_nxt        = in_program_tag;
                elapsed_nxt    = '0;
                since_nxt      = '0;
                next_nxt       = '0;
                out_strobe_nxt = 1'b1;
                out_kind_nxt   = KIND_STATE;
                out_mode_nxt   = MODE_ACTIVE;
                out_tag_nxt    = in_program_tag;
                out_last_nxt   = 1'b1;
              end
            end
            FN_ESTOP: begin
              if (mode_r == MODE_ACTIVE) begin
                state_nxt = S_END;
              end
            end
            FN_SHUT: begin
              if (mode_r != MODE_STOPPING) begin
                mode_nxt       = MODE_STOPPING;
                out_strobe_nxt = 1'b1;
                out_kind_nxt   = KIND_STATE;
                out_mode_nxt   = MODE_STOPPING;
                out_last_nxt   = (shut_cnt == '0);
                sh_cnt_nxt     = shut_cnt;
                sh_i_nxt       = PUMP_W'(1);
                if (shut_cnt != '0) begin
                  state_nxt = S_SHUT;
                end
              end
            end
            FN_TICK: begin
              if (mode_r == MODE_ACTIVE && next_r < total_r) begin
                if (elapsed_r != TIME_MAX) begin
                  elapsed_nxt = elapsed_r + 1'b1;
                end
                ram_re    = 1'b1;
                state_nxt = S_TRD;
              end
            end
            default: ;
          endcase
        end
      end

      S_TRD: begin
        // head of the next group is on the read port
        gt_nxt        = rd_time;
        cur_pump_nxt  = rd_pump;
        cur_level_nxt = rd_level;
        due_nxt       = due_now;
        if (due_now || since_inc >= {1'b0, interval_r}) begin
          since_nxt = '0;
          state_nxt = S_PCT;
        end else begin
          since_nxt = since_inc[IVAL_W-1:0];
          state_nxt = S_WAIT;
        end
      end

      S_PCT: begin
        rem_nxt  = NUM_W'(elapsed_r) * NUM_W'(PCT_FULL);
        dsh_nxt  = NUM_W'(last_time_r) << (PCT_W - 1);
        q_nxt    = '0;
        step_nxt = '0;
        // elapsed at or past the end time saturates, skip the divide
        state_nxt = (elapsed_r >= last_time_r) ? S_PEMIT : S_DIV;
      end

      S_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_nxt = rem_r - dsh_r;
          q_nxt   = {q_r[PCT_W-2:0], 1'b1};
        end else begin
          q_nxt   = {q_r[PCT_W-2:0], 1'b0};
        end
        dsh_nxt  = dsh_r >> 1;
        step_nxt = step_r + 1'b1;
        if (step_r == DIV_LAST) begin
          state_nxt = S_PEMIT;
        end
      end

      S_PEMIT: begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_PROGRESS;
        out_pct_nxt    = (elapsed_r >= last_time_r) ? PCT_FULL : q_r;
        out_last_nxt   = !due_r;
        fired_nxt      = '0;
        state_nxt      = due_r ? S_FA : S_WAIT;
      end

      S_FA: begin
        // read ahead so the current set knows whether it is the final one
        ram_re    = 1'b1;
        ram_raddr = next_inc[ADDR_W-1:0];
        state_nxt = S_FB;
      end

      S_FB: begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_PUMP;
        out_pump_nxt   = cur_pump_r;
        out_level_nxt  = cur_level_r;
        out_last_nxt   = !more && !table_end;
        next_nxt       = next_inc;
        fired_nxt      = fired_r + 1'b1;
        cur_pump_nxt   = rd_pump;
        cur_level_nxt  = rd_level;
        if (more) begin
          state_nxt = S_FA;
        end else if (table_end) begin
          state_nxt = S_P100;
        end else begin
          state_nxt = S_WAIT;
        end
      end

      S_P100: begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_PROGRESS;
        out_pct_nxt    = PCT_FULL;
        state_nxt      = S_END;
      end

      S_END: begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_ENDED;
        state_nxt      = S_END2;
      end

      S_END2: begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_STATE;
        out_mode_nxt   = MODE_IDLE;
        out_last_nxt   = 1'b1;
        mode_nxt       = MODE_IDLE;
        total_nxt      = '0;
        next_nxt       = '0;
        state_nxt      = S_WAIT;
      end

      S_SHUT: begin
        out_strobe_nxt = 1'b1;
        out_kind_nxt   = KIND_PUMP;
        out_pump_nxt   = sh_i_r;
        out_last_nxt   = (sh_i_r == sh_cnt_r);
        sh_i_nxt       = sh_i_r + 1'b1;
        if (sh_i_r == sh_cnt_r) begin
          state_nxt = S_WAIT;
        end
      end

      default: state_nxt = S_WAIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_WAIT;
      mode_r       <= MODE_IDLE;
      total_r      <= '0;
      next_r       <= '0;
      elapsed_r    <= '0;
      since_r      <= '0;
      tag_r        <= '0;
      pump_count_r <= PUMP_CNT_RST;
      interval_r   <= IVAL_RST;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      mode_r       <= mode_nxt;
      total_r      <= total_nxt;
      next_r       <= next_nxt;
      elapsed_r    <= elapsed_nxt;
      since_r      <= since_nxt;
      tag_r        <= tag_nxt;
      out_strobe_r <= out_strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PUMP_COUNT: pump_count_r <= cfg_data[PUMP_W-1:0];
          CFG_INTERVAL:   interval_r   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    last_time_r <= last_time_nxt;
    gt_r        <= gt_nxt;
    cur_pump_r  <= cur_pump_nxt;
    cur_level_r <= cur_level_nxt;
    due_r       <= due_nxt;
    fired_r     <= fired_nxt;
    rem_r       <= rem_nxt;
    dsh_r       <= dsh_nxt;
    q_r         <= q_nxt;
    step_r      <= step_nxt;
    sh_i_r      <= sh_i_nxt;
    sh_cnt_r    <= sh_cnt_nxt;
    out_kind_r  <= out_kind_nxt;
    out_pump_r  <= out_pump_nxt;
    out_level_r <= out_level_nxt;
    out_pct_r   <= out_pct_nxt;
    out_mode_r  <= out_mode_nxt;
    out_tag_r   <= out_tag_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_strobe      = out_strobe_r;
  assign out_kind        = out_kind_r;
  assign out_pump        = out_pump_r;
  assign out_level       = out_level_r;
  assign out_percent     = out_pct_r;
  assign out_runner_mode = out_mode_r;
  assign out_tag         = out_tag_r;
  assign out_last        = out_last_r;

endmodule

/* rtl/tes_ram.sv */
// ----------------------------------------------------------------------------
// tes_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module tes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* tb/sv/timed_event_sequencer_test.sv */
// ----------------------------------------------------------------------------
// timed_event_sequencer_test
// Self-checking bench for the timed event sequencer. Directed requests hit
// the ignored cases, the table edges and the end of a program. Random
// programs follow, each loaded, started and then ticked. A small scoreboard
// predicts every result and compares each strobed result field by field.
// ----------------------------------------------------------------------------
module timed_event_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import tes_pkg::*;

  localparam int REQ_TARGET    = 145;
  localparam int TIME_LIMIT    = 400000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PCT_SCALE     = 100;
  localparam logic [2:0] FN_SPARE_LO = 3'd5;
  localparam logic [2:0] FN_SPARE_HI = 3'd7;
  localparam int PUMP_MAX_CODE = (1 << PUMP_W) - 1;

  typedef struct {
    logic [2:0]         func;
    logic [TIME_W-1:0]  event_ms;
    logic [PUMP_W-1:0]  pump;
    logic [LEVEL_W-1:0] level;
    logic [TAG_W-1:0]   tag;
  } request_t;

  typedef struct {
    logic [1:0]         kind;
    logic [PUMP_W-1:0]  pump;
    logic [LEVEL_W-1:0] level;
    logic [PCT_W-1:0]   pct;
    logic [1:0]         mode;
    logic [TAG_W-1:0]   tag;
    logic               last;
  } report_t;

  class pump_scoreboard;
    logic [PUMP_W-1:0]  pump_count = PUMP_CNT_RST;
    logic [IVAL_W-1:0]  interval   = IVAL_RST;
    mode_t              mode       = MODE_IDLE;
    logic [TIME_W-1:0]  ev_ms    [MAX_EVENTS_DEF];
    logic [PUMP_W-1:0]  ev_pump  [MAX_EVENTS_DEF];
    logic [LEVEL_W-1:0] ev_level [MAX_EVENTS_DEF];
    int                 entries   = 0;
    int                 next_idx  = 0;
    logic [TIME_W-1:0]  elapsed   = '0;
    int                 since_rep = 0;
    logic [TAG_W-1:0]   tag       = '0;
    report_t            awaited[$];
    int                 errors    = 0;

    function void set_register(logic idx, logic [IVAL_W-1:0] data);
      if (idx == CFG_PUMP_COUNT) begin
        pump_count = data[PUMP_W-1:0];
      end else begin
        interval = data;
      end
    endfunction

    function void push(logic [1:0] kind, logic [PUMP_W-1:0] pump,
                       logic [LEVEL_W-1:0] level, logic [PCT_W-1:0] pct,
                       logic [1:0] rmode);
      report_t r;
      r.kind  = kind;
      r.pump  = pump;
      r.level = level;
      r.pct   = pct;
      r.mode  = rmode;
      r.tag   = tag;
      r.last  = 1'b0;
      awaited.push_back(r);
    endfunction

    function logic [PCT_W-1:0] percent_now();
      logic [TIME_W-1:0] span;
      longint unsigned   p;
      span = ev_ms[entries-1];
      if (span == 0) return PCT_FULL;
      p = elapsed;
      p = (p * PCT_SCALE) / span;
      return (p > PCT_FULL) ? PCT_FULL : p[PCT_W-1:0];
    endfunction

    function void finish_program();
      push(KIND_ENDED, 0, 0, 0, 0);
      mode = MODE_IDLE;
      push(KIND_STATE, 0, 0, 0, MODE_IDLE);
      entries  = 0;
      next_idx = 0;
    endfunction

    // Returns 1 when the request changes state or causes results.
    function bit note_request(request_t r);
      int                before_n;
      int                fired;
      int                cnt;
      int                lim;
      bit                due;
      bit                took;
      logic [TIME_W-1:0] grp;
      report_t           tail;
      before_n = awaited.size();
      took = 1'b0;
      case (r.func)
        FN_LOAD: begin
          if (mode == MODE_IDLE && entries < MAX_EVENTS_DEF &&
              r.pump >= 1 && r.pump <= PUMPS_DEF &&
              (entries == 0 || r.event_ms >= ev_ms[entries-1])) begin
            ev_ms[entries]    = r.event_ms;
            ev_pump[entries]  = r.pump;
            ev_level[entries] = r.level;
            entries++;
            took = 1'b1;
          end
        end
        FN_START: begin
          if (mode == MODE_IDLE && entries > 0) begin
            mode      = MODE_ACTIVE;
            tag       = r.tag;
            elapsed   = '0;
            since_rep = 0;
            next_idx  = 0;
            push(KIND_STATE, 0, 0, 0, MODE_ACTIVE);
            took = 1'b1;
          end
        end
        FN_ESTOP: begin
          if (mode == MODE_ACTIVE) begin
            finish_program();
            took = 1'b1;
          end
        end
        FN_SHUT: begin
          if (mode != MODE_STOPPING) begin
            mode = MODE_STOPPING;
            push(KIND_STATE, 0, 0, 0, MODE_STOPPING);
            lim = pump_count;
            if (lim > PUMPS_DEF) lim = PUMPS_DEF;
            if (lim > SETS_PER_TICK) lim = SETS_PER_TICK;
            for (int i = 1; i <= lim; i++) push(KIND_PUMP, i, 0, 0, 0);
            took = 1'b1;
          end
        end
        FN_TICK: begin
          if (mode == MODE_ACTIVE && next_idx < entries) begin
            cnt = since_rep + 1;
            if (elapsed != TIME_MAX) elapsed++;
            due = elapsed >= ev_ms[next_idx];
            if (due || cnt >= interval) begin
              push(KIND_PROGRESS, 0, 0, percent_now(), 0);
              since_rep = 0;
            end else begin
              since_rep = cnt;
            end
            if (due) begin
              // fire at most one tick's worth of the due group
              grp   = ev_ms[next_idx];
              fired = 0;
              while (next_idx < entries && fired < SETS_PER_TICK &&
                     ev_ms[next_idx] == grp) begin
                push(KIND_PUMP, ev_pump[next_idx], ev_level[next_idx], 0, 0);
                next_idx++;
                fired++;
              end
              if (next_idx >= entries) begin
                push(KIND_PROGRESS, 0, 0, PCT_FULL, 0);
                finish_program();
              end
            end
            took = 1'b1;
          end
        end
        default: ;
      endcase
      if (awaited.size() > before_n) begin
        tail = awaited.pop_back();
        tail.last = 1'b1;
        awaited.push_back(tail);
      end
      return took;
    endfunction

    function void match_field(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(report_t got);
      report_t want;
      if (awaited.size() == 0) begin
        $error("out_kind: result %0d with nothing awaited", got.kind);
        errors++;
        return;
      end
      want = awaited.pop_front();
      match_field("out_kind", want.kind, got.kind);
      match_field("out_pump", want.pump, got.pump);
      match_field("out_level", want.level, got.level);
      match_field("out_percent", want.pct, got.pct);
      match_field("out_runner_mode", want.mode, got.mode);
      match_field("out_tag", want.tag, got.tag);
      match_field("out_last", want.last, got.last);
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         in_func = FN_LOAD;
  logic [TIME_W-1:0]  in_event_time_ms = '0;
  logic [PUMP_W-1:0]  in_pump_index = '0;
  logic [LEVEL_W-1:0] in_pump_level = '0;
  logic [TAG_W-1:0]   in_program_tag = '0;
  logic               out_strobe;
  logic [1:0]         out_kind;
  logic [PUMP_W-1:0]  out_pump;
  logic [LEVEL_W-1:0] out_level;
  logic [PCT_W-1:0]   out_percent;
  logic [1:0]         out_runner_mode;
  logic [TAG_W-1:0]   out_tag;
  logic               out_last;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic               cfg_index = CFG_PUMP_COUNT;
  logic [IVAL_W-1:0]  cfg_data = '0;

  pump_scoreboard sb = new;
  int cycles      = 0;
  int sent_reqs   = 0;
  int burst_left  = 0;

  timed_event_sequencer dut (.*);

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > TIME_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : result_monitor
    report_t got;
    if (rst_n && out_strobe) begin
      got.kind  = out_kind;
      got.pump  = out_pump;
      got.level = out_level;
      got.pct   = out_percent;
      got.mode  = out_runner_mode;
      got.tag   = out_tag;
      got.last  = out_last;
      sb.check_result(got);
    end
  end

  function automatic request_t make_req(logic [2:0] func, logic [TIME_W-1:0] t,
                                        logic [PUMP_W-1:0] pump,
                                        logic [LEVEL_W-1:0] level,
                                        logic [TAG_W-1:0] tag);
    request_t r;
    r.func     = func;
    r.event_ms = t;
    r.pump     = pump;
    r.level    = level;
    r.tag      = tag;
    return r;
  endfunction

  function automatic request_t random_fields(logic [2:0] func);
    return make_req(func, $urandom, $urandom_range(0, PUMP_MAX_CODE),
                    $urandom, $urandom);
  endfunction

  // Build a request that the block must drop in its current mode.
  function automatic request_t noise_request();
    request_t r;
    int       pick;
    r = random_fields(FN_SPARE_LO);
    pick = $urandom_range(0, 4);
    if (sb.mode == MODE_ACTIVE) begin
      case (pick)
        0: r.func = FN_LOAD;
        1: r.func = FN_START;
        default: r.func = $urandom_range(FN_SPARE_LO, FN_SPARE_HI);
      endcase
    end else begin
      case (pick)
        0: r.func = FN_ESTOP;
        1: r.func = FN_TICK;
        2: r.func = $urandom_range(FN_SPARE_LO, FN_SPARE_HI);
        default: begin
          r.func = FN_LOAD;
          if (pick == 4 && sb.entries > 0 && sb.ev_ms[sb.entries-1] > 0) begin
            r.pump     = $urandom_range(1, PUMPS_DEF);
            r.event_ms = $urandom_range(0, sb.ev_ms[sb.entries-1] - 1);
          end else begin
            r.pump = $urandom_range(0, 1) ? '0
                                          : $urandom_range(PUMPS_DEF + 1, PUMP_MAX_CODE);
          end
        end
      endcase
      if (sb.entries == 0 && pick == 1) r.func = FN_START;
    end
    return r;
  endfunction

  task automatic send_request(request_t r);
    @(negedge clk);
    start            = 1'b1;
    in_func          = r.func;
    in_event_time_ms = r.event_ms;
    in_pump_index    = r.pump;
    in_pump_level    = r.level;
    in_program_tag   = r.tag;
    do @(posedge clk); while (busy);
    void'(sb.note_request(r));
    sent_reqs++;
  endtask

  // Keep start high inside a burst, and between bursts mostly drop it for a random gap.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    burst_left = $urandom_range(1, 12);
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
    if (gap > 0) begin
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic issue(request_t r);
    if ($urandom_range(0, 6) == 0) begin
      pace();
      send_request(noise_request());
    end
    pace();
    send_request(r);
  endtask

  task automatic send_plain(logic [2:0] func, logic [TIME_W-1:0] t,
                            logic [PUMP_W-1:0] pump, logic [LEVEL_W-1:0] level,
                            logic [TAG_W-1:0] tag);
    pace();
    send_request(make_req(func, t, pump, level, tag));
  endtask

  task automatic wait_quiet();
    @(negedge clk);
    start = 1'b0;
    while (sb.awaited.size() != 0 || busy) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(logic idx, logic [IVAL_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_register(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [IVAL_W-1:0] pick_pump_count(int phase);
    case (phase % 4)
      0: return 1;
      1: return PUMPS_DEF;
      2: return PUMP_MAX_CODE;
      default: return $urandom_range(1, PUMPS_DEF);
    endcase
  endfunction

  task automatic configure(int phase);
    logic [IVAL_W-1:0] ival;
    case (phase % 5)
      0: ival = '0;
      1: ival = 1;
      2: ival = '1;
      3: ival = $urandom_range(2, 5);
      default: ival = $urandom_range(1, 65535);
    endcase
    if ($urandom_range(0, 1)) begin
      write_register(CFG_PUMP_COUNT, pick_pump_count(phase));
      write_register(CFG_INTERVAL, ival);
    end else begin
      write_register(CFG_INTERVAL, ival);
      write_register(CFG_PUMP_COUNT, pick_pump_count(phase));
    end
  endtask

  // Load a nondecreasing program, start it and tick it to its end or a random stop.
  // Far programs sit beyond reach and get an emergency stop instead.
  task automatic run_program(bit far_times);
    int                n;
    int                ticks;
    int                stop_after;
    bit                flat;
    logic [TIME_W-1:0] t;
    request_t          r;
    flat = 1'b0;
    if (far_times) begin
      n = $urandom_range(1, 4);
      t = $urandom_range(1 << 20, TIME_MAX - 64);
    end else begin
      if ($urandom_range(0, 11) == 0) begin
        n    = $urandom_range(SETS_PER_TICK + 1, MAX_EVENTS_DEF + 2);
        flat = $urandom_range(0, 1);
      end else begin
        n = $urandom_range(1, 6);
      end
      t = $urandom_range(0, 3);
    end
    for (int i = 0; i < n; i++) begin
      r = random_fields(FN_LOAD);
      r.event_ms = t;
      r.pump     = $urandom_range(1, PUMPS_DEF);
      issue(r);
      if (!flat && $urandom_range(0, 2) == 0) t += $urandom_range(1, 4);
    end
    issue(random_fields(FN_START));
    ticks = 0;
    stop_after = $urandom_range(1, 6);
    while (sb.mode == MODE_ACTIVE) begin
      if ((far_times && ticks >= stop_after) || $urandom_range(0, 59) == 0) begin
        r = random_fields(FN_ESTOP);
      end else begin
        r = random_fields(FN_TICK);
      end
      // hold off now and then until every pending result is out
      if ($urandom_range(0, 29) == 0) wait_quiet();
      issue(r);
      ticks++;
    end
  endtask

  initial begin
    int phase;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // dropped requests while idle
    send_plain(FN_TICK, TIME_MAX, PUMP_MAX_CODE, 8'hFF, 8'hFF);
    send_plain(FN_START, 0, 1, 0, 8'h5A);
    send_plain(FN_ESTOP, 0, 0, 0, 0);
    for (int f = FN_SPARE_LO; f <= FN_SPARE_HI; f++) begin
      send_plain(f, TIME_MAX, PUMP_MAX_CODE, 8'hFF, 8'hFF);
    end
    // table edges: bad pumps, a time that goes back
    send_plain(FN_LOAD, 0, 1, 8'h00, 0);
    send_plain(FN_LOAD, 0, PUMPS_DEF, 8'hFF, 0);
    send_plain(FN_LOAD, 5, 0, 8'h11, 0);
    send_plain(FN_LOAD, 5, PUMPS_DEF + 1, 8'h22, 0);
    send_plain(FN_LOAD, 3, 2, 8'hAA, 0);
    send_plain(FN_LOAD, 2, 3, 8'h55, 0);
    send_plain(FN_START, 0, 0, 0, 8'hFF);
    send_plain(FN_LOAD, 9, 4, 8'h01, 0);
    send_plain(FN_START, 0, 0, 0, 8'h01);
    repeat (3) send_plain(FN_TICK, 0, 0, 0, 0);
    // far end time, then emergency stop
    send_plain(FN_LOAD, TIME_MAX, 8, 8'h80, 0);
    send_plain(FN_START, 0, 0, 0, 8'h00);
    send_plain(FN_TICK, 0, 0, 0, 0);
    send_plain(FN_ESTOP, 0, 0, 0, 0);
    // last entry at time zero
    send_plain(FN_LOAD, 0, PUMPS_DEF, 8'h07, 0);
    send_plain(FN_START, 0, 0, 0, 8'h81);
    send_plain(FN_TICK, 0, 0, 0, 0);

    phase = 0;
    while (sent_reqs < REQ_TARGET) begin
      wait_quiet();
      configure(phase);
      repeat (3) run_program($urandom_range(0, 7) == 0);
      phase++;
    end

    // shutdown is terminal, so it closes the run
    wait_quiet();
    write_register(CFG_PUMP_COUNT, pick_pump_count($urandom_range(0, 3)));
    if ($urandom_range(0, 1)) begin
      send_plain(FN_LOAD, 50, $urandom_range(1, PUMPS_DEF), $urandom, 0);
      send_plain(FN_START, 0, 0, 0, $urandom);
      repeat ($urandom_range(0, 3)) send_plain(FN_TICK, 0, 0, 0, 0);
    end
    send_plain(FN_SHUT, $urandom, $urandom, $urandom, $urandom);
    for (int f = FN_LOAD; f <= FN_SPARE_HI; f++) begin
      pace();
      send_request(random_fields(f));
    end

    wait_quiet();
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/tes_pkg.sv
rtl/tes_ram.sv
rtl/timed_event_sequencer.sv
tb/sv/timed_event_sequencer_test.sv
